// ===== hw/rtl/ptzt_pkg.sv =====
package ptzt_pkg;

  localparam int YEAR_W = 14;
  localparam int DAY_W  = 23;
  localparam int RULE_W = 42;
  localparam int OFF_W  = 18;
  localparam int INST_W = 59;

  localparam logic [1:0] KIND_M = 2'd0;
  localparam logic [1:0] KIND_J = 2'd1;

  // years are shifted by 400 so that day counts stay positive
  localparam logic [14:0] YEAR_BIAS   = 15'd399;
  localparam logic [12:0] DIV100_MUL  = 13'd5243;
  localparam int          DIV100_SHR  = 19;
  localparam logic [25:0] DIV7_MUL    = 26'd38347923;
  localparam int          DIV7_SHR    = 28;
  localparam logic [24:0] EPOCH_DAYS  = 25'd865565;
  localparam logic [8:0]  JAN1_DOY    = 9'd306;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [19:0] US_PER_SEC  = 20'd1000000;

  typedef enum logic [2:0] {
    CFG_START_RULE,
    CFG_END_RULE,
    CFG_STD_OFFSET,
    CFG_DST_OFFSET,
    CFG_HAS_DST,
    CFG_WIN_START,
    CFG_WIN_END,
    CFG_LAST_EXPLICIT
  } ptzt_cfg_idx_t;

  typedef struct packed {
    logic [DAY_W-1:0] base;
    logic             leap;
  } ptzt_year_t;

  // day of the march-based year on which the month begins
  function automatic logic [8:0] month_doy(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd306;
      4'd2:    d = 9'd337;
      4'd3:    d = 9'd0;
      4'd4:    d = 9'd31;
      4'd5:    d = 9'd61;
      4'd6:    d = 9'd92;
      4'd7:    d = 9'd122;
      4'd8:    d = 9'd153;
      4'd9:    d = 9'd184;
      4'd10:   d = 9'd214;
      4'd11:   d = 9'd245;
      4'd12:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/ptzt_rule_pipe.sv =====
module ptzt_rule_pipe (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [ptzt_pkg::RULE_W-1:0]          rule,
  input  logic signed [ptzt_pkg::OFF_W-1:0]    offset,
  input  ptzt_pkg::ptzt_year_t                 yr,
  output logic signed [63:0]                   inst
);

  logic [1:0]  kind;
  logic [3:0]  mon_raw, mon;
  logic [2:0]  wk_raw, wk, wday;
  logic [8:0]  yday;
  logic signed [20:0] secs;
  logic        is_m;

  assign kind    = rule[1:0];
  assign mon_raw = rule[5:2];
  assign wk_raw  = rule[8:6];
  assign yday    = rule[20:12];
  assign secs    = $signed(rule[41:21]);
  assign is_m    = (kind == ptzt_pkg::KIND_M);
  assign mon     = (mon_raw == 4'd0) ? 4'd1 : ((mon_raw > 4'd12) ? 4'd12 : mon_raw);
  assign wk      = (wk_raw == 3'd0) ? 3'd1 : ((wk_raw > 3'd5) ? 3'd5 : wk_raw);
  assign wday    = (rule[11:9] == 3'd7) ? 3'd0 : rule[11:9];

  // stage 1: first of month and j/n day, as shifted day counts
  logic [ptzt_pkg::DAY_W-1:0] base_sel, first_nxt, jan1, jn_nxt;
  logic [ptzt_pkg::DAY_W-1:0] first1_r, jn1_r;
  logic                       leap1_r;

  assign base_sel  = (mon <= 4'd2) ? yr.base
                                   : yr.base + 23'd365 + ptzt_pkg::DAY_W'(yr.leap);
  assign first_nxt = base_sel + ptzt_pkg::DAY_W'(ptzt_pkg::month_doy(mon));
  assign jan1      = yr.base + ptzt_pkg::DAY_W'(ptzt_pkg::JAN1_DOY);
  assign jn_nxt    = (kind == ptzt_pkg::KIND_J)
                     ? jan1 + ptzt_pkg::DAY_W'(yday)
                       + ptzt_pkg::DAY_W'(yr.leap && (yday >= 9'd60)) - 23'd1
                     : jan1 + ptzt_pkg::DAY_W'(yday);

  always_ff @(posedge clk) begin
    if (en) begin
      first1_r <= first_nxt;
      jn1_r    <= jn_nxt;
      leap1_r  <= yr.leap;
    end
  end

  // stage 2: quotient by 7 for the weekday
  logic [23:0] d3;
  logic [49:0] prod7;
  logic [21:0] q7_r;
  logic [ptzt_pkg::DAY_W-1:0] first2_r, jn2_r;
  logic                       leap2_r;

  assign d3    = 24'(first1_r) + 24'd3;
  assign prod7 = 50'(d3) * 50'(ptzt_pkg::DIV7_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      q7_r     <= prod7[ptzt_pkg::DIV7_SHR +: 22];
      first2_r <= first1_r;
      jn2_r    <= jn1_r;
      leap2_r  <= leap1_r;
    end
  end

  // stage 3: day of month for m rules
  logic [23:0] fw_full;
  logic [2:0]  fw, t7;
  logic [3:0]  t;
  logic [5:0]  md, md_nxt, md3_r;
  logic [4:0]  mlen;
  logic [ptzt_pkg::DAY_W-1:0] first3_r, jn3_r;

  assign fw_full = 24'(first2_r) + 24'd3 - 24'(q7_r) * 24'd7;
  assign fw      = fw_full[2:0];
  assign t       = {1'b0, wday} + 4'd7 - {1'b0, fw};
  assign t7      = (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
  assign md      = 6'd1 + 6'(t7) + 6'(3'(wk - 3'd1)) * 6'd7;
  assign mlen    = ptzt_pkg::month_len(mon, leap2_r);
  assign md_nxt  = (md > 6'(mlen)) ? md - 6'd7 : md;

  always_ff @(posedge clk) begin
    if (en) begin
      md3_r    <= md_nxt;
      first3_r <= first2_r;
      jn3_r    <= jn2_r;
    end
  end

  // stage 4: day number since 1970
  logic [ptzt_pkg::DAY_W-1:0] day_d;
  logic signed [24:0]         day_nxt, day4_r;

  assign day_d   = is_m ? first3_r + ptzt_pkg::DAY_W'(md3_r) - 23'd1 : jn3_r;
  assign day_nxt = $signed({2'b00, day_d}) - $signed(ptzt_pkg::EPOCH_DAYS);

  always_ff @(posedge clk) begin
    if (en) begin
      day4_r <= day_nxt;
    end
  end

  // stage 5: day to seconds
  logic signed [42:0] pd_nxt, pd5_r;

  assign pd_nxt = 43'(day4_r) * $signed(43'(ptzt_pkg::SECS_PER_DAY));

  always_ff @(posedge clk) begin
    if (en) begin
      pd5_r <= pd_nxt;
    end
  end

  // stage 6: add rule time, remove offset in force
  logic signed [43:0] loc_nxt, loc6_r;

  assign loc_nxt = 44'(pd5_r) + 44'(secs) - 44'(offset);

  always_ff @(posedge clk) begin
    if (en) begin
      loc6_r <= loc_nxt;
    end
  end

  // stage 7: seconds to microseconds
  logic signed [63:0] inst_nxt, inst7_r;

  assign inst_nxt = 64'(loc6_r) * $signed(64'(ptzt_pkg::US_PER_SEC));

  always_ff @(posedge clk) begin
    if (en) begin
      inst7_r <= inst_nxt;
    end
  end

  assign inst = inst7_r;

endmodule

// ===== hw/rtl/posix_tz_rule_transitions.sv =====
// posix_tz_rule_transitions
// Takes one gregorian year per transfer on the in_ stream and returns the
// daylight-saving transitions of that year under the configured start and
// end rules on the out_ stream, in time order, zero to two per year, the
// last one of a year marked with out_tlast.
// Rules, offsets, window and drop limit are written on the cfg_ port; the
// user must write them only while the block is idle, which the block
// does not enforce; they take effect for the years accepted afterwards.
// A year's transfer loads the first of 2 year stages; 7 rule stages, a
// keep/order stage and the output register follow before a result appears
// on out_tvalid. Throughput: one year per cycle while the receiver is ready
// and each year keeps at most one transition; a year that keeps two holds
// the output register for both of its transfers, so the single output port
// sets the rate. Years that keep no transition pass through without using
// the output. Reset clears all valid bits and the output register's control
// bits and loads the configuration defaults. When the receiver stalls, the
// output register holds and the whole pipeline freezes once its last stage
// holds a year with a result; in_tready is then low until the output drains.
module posix_tz_rule_transitions (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // year[13:0], zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // instant[58:0], offset_before[76:59],
                                   // offset_after[94:77], zero fill
  output logic         out_tuser,  // enters_daylight
  output logic         out_tlast,  // last_of_run
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam int NSTG = 10;
  localparam int IW   = ptzt_pkg::INST_W;
  localparam int OW   = ptzt_pkg::OFF_W;

  // configuration registers
  logic [ptzt_pkg::RULE_W-1:0] start_rule_r, end_rule_r;
  logic signed [OW-1:0]        std_off_r, dst_off_r;
  logic                        has_dst_r;
  logic signed [IW-1:0]        win_lo_r, win_hi_r;
  logic signed [63:0]          last_exp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_rule_r <= 42'd15099494402;
      end_rule_r   <= 42'd15099494402;
      std_off_r    <= '0;
      dst_off_r    <= 18'sd3600;
      has_dst_r    <= 1'b0;
      win_lo_r     <= '0;
      win_hi_r     <= 59'sd253402300800000000;
      last_exp_r   <= 64'sh8000000000000000;
    end else if (cfg_wr_en) begin
      unique case (ptzt_pkg::ptzt_cfg_idx_t'(cfg_index))
        ptzt_pkg::CFG_START_RULE:    start_rule_r <= cfg_data[ptzt_pkg::RULE_W-1:0];
        ptzt_pkg::CFG_END_RULE:      end_rule_r   <= cfg_data[ptzt_pkg::RULE_W-1:0];
        ptzt_pkg::CFG_STD_OFFSET:    std_off_r    <= $signed(cfg_data[OW-1:0]);
        ptzt_pkg::CFG_DST_OFFSET:    dst_off_r    <= $signed(cfg_data[OW-1:0]);
        ptzt_pkg::CFG_HAS_DST:       has_dst_r    <= cfg_data[0];
        ptzt_pkg::CFG_WIN_START:     win_lo_r     <= $signed(cfg_data[IW-1:0]);
        ptzt_pkg::CFG_WIN_END:       win_hi_r     <= $signed(cfg_data[IW-1:0]);
        ptzt_pkg::CFG_LAST_EXPLICIT: last_exp_r   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSTG-1:0] valid_r;
  logic            en;
  logic            tail_has;
  logic            e_valid_r, e_two_r, e_idx_r;
  logic            out_xfer, e_done, e_free, e_load;

  assign out_xfer = out_tvalid && out_tready;
  assign e_done   = out_xfer && out_tlast;
  assign e_free   = !e_valid_r || e_done;
  assign en       = !(valid_r[NSTG-1] && tail_has && !e_free);
  assign e_load   = valid_r[NSTG-1] && tail_has && e_free;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NSTG-2:0], in_tvalid};
    end
  end

  // year stage 1: reciprocal products for the century terms
  logic [ptzt_pkg::YEAR_W-1:0] y;
  logic [14:0] yp;
  logic [ptzt_pkg::YEAR_W-1:0] s1_y_r;
  logic [14:0] s1_yp_r;
  logic [27:0] s1_yp_m_r;
  logic [25:0] s1_yp4_m_r;
  logic [26:0] s1_y_m_r;
  logic [24:0] s1_y4_m_r;

  assign y  = in_tdata[ptzt_pkg::YEAR_W-1:0];
  assign yp = 15'(y) + ptzt_pkg::YEAR_BIAS;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_y_r     <= y;
      s1_yp_r    <= yp;
      s1_yp_m_r  <= 28'(yp) * 28'(ptzt_pkg::DIV100_MUL);
      s1_yp4_m_r <= 26'(yp[14:2]) * 26'(ptzt_pkg::DIV100_MUL);
      s1_y_m_r   <= 27'(y) * 27'(ptzt_pkg::DIV100_MUL);
      s1_y4_m_r  <= 25'(y[13:2]) * 25'(ptzt_pkg::DIV100_MUL);
    end
  end

  // year stage 2: day count before march 1 and leap flag
  logic [8:0] q100;
  logic [6:0] q400;
  logic [7:0] y100;
  logic [5:0] y4_100;
  logic       div100, div400, leap;
  ptzt_pkg::ptzt_year_t yr_nxt, yr_r;

  assign q100   = s1_yp_m_r[ptzt_pkg::DIV100_SHR +: 9];
  assign q400   = s1_yp4_m_r[ptzt_pkg::DIV100_SHR +: 7];
  assign y100   = s1_y_m_r[ptzt_pkg::DIV100_SHR +: 8];
  assign y4_100 = s1_y4_m_r[ptzt_pkg::DIV100_SHR +: 6];
  assign div100 = (s1_y_r == 14'(y100) * 14'd100);
  assign div400 = (s1_y_r[1:0] == 2'd0) && (s1_y_r[13:2] == 12'(y4_100) * 12'd100);
  assign leap   = (s1_y_r[1:0] == 2'd0) && (!div100 || div400);

  assign yr_nxt.base = 23'(s1_yp_r) * 23'd365 + 23'(s1_yp_r[14:2])
                       - 23'(q100) + 23'(q400);
  assign yr_nxt.leap = leap;

  always_ff @(posedge clk) begin
    if (en) begin
      yr_r <= yr_nxt;
    end
  end

  // rule pipelines
  logic signed [63:0] s_inst, e_inst;

  ptzt_rule_pipe u_start (
    .clk    (clk),
    .en     (en),
    .rule   (start_rule_r),
    .offset (std_off_r),
    .yr     (yr_r),
    .inst   (s_inst)
  );

  ptzt_rule_pipe u_end (
    .clk    (clk),
    .en     (en),
    .rule   (end_rule_r),
    .offset (dst_off_r),
    .yr     (yr_r),
    .inst   (e_inst)
  );

  // keep and order stage
  logic signed [63:0] lo64, hi64;
  logic               keep_s, keep_e, s_first;
  logic               keep0_r, keep1_r, s_first_r;
  logic [IW-1:0]      inst0_r, inst1_r;

  assign lo64    = 64'(win_lo_r);
  assign hi64    = 64'(win_hi_r);
  assign keep_s  = has_dst_r && (s_inst > last_exp_r) && (s_inst >= lo64) && (s_inst < hi64);
  assign keep_e  = has_dst_r && (e_inst > last_exp_r) && (e_inst >= lo64) && (e_inst < hi64);
  assign s_first = (s_inst < e_inst);

  always_ff @(posedge clk) begin
    if (en) begin
      s_first_r <= s_first;
      keep0_r   <= s_first ? keep_s : keep_e;
      keep1_r   <= s_first ? keep_e : keep_s;
      inst0_r   <= s_first ? s_inst[IW-1:0] : e_inst[IW-1:0];
      inst1_r   <= s_first ? e_inst[IW-1:0] : s_inst[IW-1:0];
    end
  end

  assign tail_has = keep0_r || keep1_r;

  // output register, up to two results per year
  logic [IW-1:0] e_inst0_r, e_inst1_r, cur_inst;
  logic          e_dst0_r, e_dst1_r, cur_dst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      e_two_r   <= 1'b0;
      e_idx_r   <= 1'b0;
    end else if (e_load) begin
      e_valid_r <= 1'b1;
      e_two_r   <= keep0_r && keep1_r;
      e_idx_r   <= 1'b0;
    end else if (e_done) begin
      e_valid_r <= 1'b0;
      e_idx_r   <= 1'b0;
    end else if (out_xfer) begin
      e_idx_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (e_load) begin
      e_inst0_r <= keep0_r ? inst0_r : inst1_r;
      e_dst0_r  <= keep0_r ? s_first_r : !s_first_r;
      e_inst1_r <= inst1_r;
      e_dst1_r  <= !s_first_r;
    end
  end

  assign cur_inst   = e_idx_r ? e_inst1_r : e_inst0_r;
  assign cur_dst    = e_idx_r ? e_dst1_r : e_dst0_r;
  assign out_tvalid = e_valid_r;
  assign out_tlast  = !e_two_r || e_idx_r;
  assign out_tuser  = cur_dst;
  assign out_tdata  = {1'b0,
                       cur_dst ? dst_off_r : std_off_r,
                       cur_dst ? std_off_r : dst_off_r,
                       cur_inst};

  // checks
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (valid_r[NSTG-1] && tail_has && out_tvalid && !(out_tready && out_tlast)))
    else $error("input stalled without a blocked result");

  a_second_slot: assert property (@(posedge clk) disable iff (!rst_n)
    e_idx_r |-> (e_valid_r && e_two_r))
    else $error("second result selected for a single-result year");

  a_no_dst: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[NSTG-1] && !has_dst_r) |-> !tail_has)
    else $error("transition kept with daylight saving off");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (e_done && !e_load) |=> !out_tvalid)
    else $error("output still valid after its last transfer");

endmodule

// ===== dv/posix_tz_rule_transitions_checker.sv =====
`timescale 1ns / 100ps

module posix_tz_rule_transitions_checker
  import ptzt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          awaited,
  output int          transitions_seen
);

  typedef struct packed {
    logic [INST_W-1:0] when_us;
    logic [OFF_W-1:0]  offset_before;
    logic [OFF_W-1:0]  offset_after;
    logic              enters_dst;
    logic              last;
  } transition_t;

  transition_t expected_q[$];
  transition_t head;

  logic [RULE_W-1:0]        start_rule;
  logic [RULE_W-1:0]        end_rule;
  logic signed [OFF_W-1:0]  std_off;
  logic signed [OFF_W-1:0]  dst_off;
  logic                     has_dst;
  logic signed [INST_W-1:0] win_lo;
  logic signed [INST_W-1:0] win_hi;
  logic signed [63:0]       drop_limit;

  function automatic bit is_leap(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // days since 1970-01-01 of a proleptic gregorian date
  function automatic longint day_number(longint y, longint m, longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic longint days_in_month(longint y, longint m);
    case (m) inside
      2:               return is_leap(y) ? 29 : 28;
      4, 6, 9, 11:     return 30;
      default:         return 31;
    endcase
  endfunction

  function automatic longint rule_local_seconds(logic [RULE_W-1:0] rule, longint y);
    logic [1:0] kind;
    longint month, week, wday, yday, secs, first, first_wday, mday, day;
    kind  = rule[1:0];
    month = longint'(rule[5:2]);
    week  = longint'(rule[8:6]);
    wday  = longint'(rule[11:9]);
    yday  = longint'(rule[20:12]);
    secs  = longint'($signed(rule[41:21]));
    if (kind == KIND_M) begin
      if (month < 1) month = 1;
      if (month > 12) month = 12;
      if (week < 1) week = 1;
      if (week > 5) week = 5;
      if (wday == 7) wday = 0;
      first = day_number(y, month, 1);
      first_wday = ((first % 7) + 11) % 7;
      mday = 1 + ((wday - first_wday + 7) % 7) + (week - 1) * 7;
      if (mday > days_in_month(y, month)) mday = mday - 7;
      day = first + mday - 1;
    end else if (kind == KIND_J) begin
      // julian day numbers skip feb 29
      day = day_number(y, 1, 1) + yday - 1;
      if (is_leap(y) && yday >= 60) day = day + 1;
    end else begin
      day = day_number(y, 1, 1) + yday;
    end
    return day * 86400 + secs;
  endfunction

  function automatic bit kept(longint inst);
    return !(inst <= drop_limit || inst < longint'(win_lo) || inst >= longint'(win_hi));
  endfunction

  function automatic transition_t make_transition(longint inst, logic [OFF_W-1:0] off_old,
                                                  logic [OFF_W-1:0] off_new, logic entering);
    transition_t t;
    t.when_us       = inst[INST_W-1:0];
    t.offset_before = off_old;
    t.offset_after  = off_new;
    t.enters_dst    = entering;
    t.last          = 1'b0;
    return t;
  endfunction

  task automatic predict_year(logic [YEAR_W-1:0] yr);
    longint y, so, dso, s_inst, e_inst;
    transition_t batch[2];
    int n;
    n = 0;
    if (!has_dst) return;
    y = longint'(yr);
    so = longint'(std_off);
    dso = longint'(dst_off);
    s_inst = (rule_local_seconds(start_rule, y) - so) * 1000000;
    e_inst = (rule_local_seconds(end_rule, y) - dso) * 1000000;
    // on a tie the return to standard time goes first
    if (s_inst < e_inst) begin
      if (kept(s_inst)) begin
        batch[n] = make_transition(s_inst, std_off, dst_off, 1'b1);
        n++;
      end
      if (kept(e_inst)) begin
        batch[n] = make_transition(e_inst, dst_off, std_off, 1'b0);
        n++;
      end
    end else begin
      if (kept(e_inst)) begin
        batch[n] = make_transition(e_inst, dst_off, std_off, 1'b0);
        n++;
      end
      if (kept(s_inst)) begin
        batch[n] = make_transition(s_inst, std_off, dst_off, 1'b1);
        n++;
      end
    end
    if (n > 0) batch[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_q.insert(expected_q.size(), batch[i]);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    mismatches++;
    $display("%0t: transfer %0d mismatch on %s: got %0d, expected %0d",
             $time, transitions_seen, field, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_rule = 42'd15099494402;
      end_rule   = 42'd15099494402;
      std_off    = '0;
      dst_off    = 18'sd3600;
      has_dst    = 1'b0;
      win_lo     = '0;
      win_hi     = 59'sd253402300800000000;
      drop_limit = {1'b1, 63'b0};
      mismatches = 0;
      transitions_seen = 0;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_START_RULE:    start_rule = cfg_data[RULE_W-1:0];
          CFG_END_RULE:      end_rule   = cfg_data[RULE_W-1:0];
          CFG_STD_OFFSET:    std_off    = cfg_data[OFF_W-1:0];
          CFG_DST_OFFSET:    dst_off    = cfg_data[OFF_W-1:0];
          CFG_HAS_DST:       has_dst    = cfg_data[0];
          CFG_WIN_START:     win_lo     = cfg_data[INST_W-1:0];
          CFG_WIN_END:       win_hi     = cfg_data[INST_W-1:0];
          CFG_LAST_EXPLICIT: drop_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_year(in_tdata[YEAR_W-1:0]);
      if (out_tvalid && out_tready) begin
        transitions_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transfer, instant",
                          longint'($signed(out_tdata[58:0])), 0);
        end else begin
          head = expected_q.pop_front();
          if (out_tdata[58:0] !== head.when_us)
            report_mismatch("instant", longint'($signed(out_tdata[58:0])),
                            longint'($signed(head.when_us)));
          if (out_tdata[76:59] !== head.offset_before)
            report_mismatch("offset_before", longint'($signed(out_tdata[76:59])),
                            longint'($signed(head.offset_before)));
          if (out_tdata[94:77] !== head.offset_after)
            report_mismatch("offset_after", longint'($signed(out_tdata[94:77])),
                            longint'($signed(head.offset_after)));
          if (out_tuser !== head.enters_dst)
            report_mismatch("enters_daylight", longint'(out_tuser), longint'(head.enters_dst));
          if (out_tlast !== head.last)
            report_mismatch("last_of_run", longint'(out_tlast), longint'(head.last));
        end
      end
    end
    awaited = expected_q.size();
  end

endmodule

// ===== dv/posix_tz_rule_transitions_test.sv =====
`timescale 1ns / 100ps

module posix_tz_rule_transitions_test;
  import ptzt_pkg::*;

  localparam logic [1:0] KIND_N   = 2'd2;
  localparam logic [1:0] KIND_ODD = 2'd3;

  localparam longint WIN_MIN     = -64'sd11644473600000000;
  localparam longint WIN_MAX     = 64'sd253402300800000000;
  localparam longint SPAN_MIN    = -(64'sd1 <<< 58);
  localparam longint SPAN_MAX    = (64'sd1 <<< 58) - 1;
  localparam longint DROP_MIN    = {1'b1, 63'b0};
  localparam longint DROP_MAX    = {1'b0, {63{1'b1}}};
  localparam longint US_PER_YEAR = 64'sd31556952000000;
  // 2000-01-11 and 2000-01-21 at midnight utc
  localparam longint JAN11_2000  = 64'sd947548800000000;
  localparam longint JAN21_2000  = 64'sd948412800000000;

  localparam int STALL_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int RANDOM_PHASES   = 10;
  localparam int YEARS_PER_PHASE = 75;

  typedef struct {
    logic [RULE_W-1:0] start_rule;
    logic [RULE_W-1:0] end_rule;
    logic [OFF_W-1:0]  std_off;
    logic [OFF_W-1:0]  dst_off;
    logic              has_dst;
    longint            win_lo;
    longint            win_hi;
    longint            drop_limit;
  } tz_settings_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int mismatches;
  int awaited;
  int transitions_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int years_sent = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  tz_settings_t zone;

  posix_tz_rule_transitions uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  posix_tz_rule_transitions_checker tz_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tlast        (out_tlast),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .awaited          (awaited),
    .transitions_seen (transitions_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d transitions awaited",
               quiet_cycles, awaited);
      $display("posix_tz_rule_transitions_test: done, errors");
      $finish;
    end
  end

  function automatic logic [RULE_W-1:0] pack_rule(logic [1:0] kind, logic [3:0] month,
                                                  logic [2:0] week, logic [2:0] wday,
                                                  logic [8:0] yday, logic [20:0] secs);
    return {secs, yday, wday, week, month, kind};
  endfunction

  function automatic logic [RULE_W-1:0] random_rule();
    int pick;
    int hours;
    logic [20:0] secs;
    pick = $urandom_range(0, 9);
    hours = $urandom_range(0, 334);
    secs = (pick == 5) ? 21'($urandom) : 21'((hours - 167) * 3600);
    if (pick <= 5)
      return pack_rule(KIND_M, 4'($urandom_range(1, 12)), 3'($urandom_range(1, 5)),
                       3'($urandom_range(0, 6)), 9'($urandom), secs);
    if (pick == 6)
      return pack_rule(KIND_J, 4'($urandom), 3'($urandom), 3'($urandom),
                       9'($urandom_range(1, 365)), secs);
    if (pick == 7)
      return pack_rule(KIND_N, 4'($urandom), 3'($urandom), 3'($urandom),
                       9'($urandom_range(0, 365)), secs);
    return {10'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [OFF_W-1:0] random_offset();
    if ($urandom_range(0, 9) < 7) return 18'(int'($urandom_range(0, 208)) * 900 - 93600);
    return 18'($urandom);
  endfunction

  function automatic longint year_instant(int yr);
    return longint'(yr - 1970) * US_PER_YEAR;
  endfunction

  function automatic tz_settings_t random_settings(int phase);
    tz_settings_t s;
    int pick;
    s.start_rule = random_rule();
    s.end_rule = random_rule();
    s.std_off = random_offset();
    s.dst_off = random_offset();
    if (phase == 0) begin
      s.std_off = 18'(-93600);
      s.dst_off = 18'(93600);
    end
    s.has_dst = (phase != 3);
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      s.win_lo = WIN_MIN;
      s.win_hi = WIN_MAX;
    end else if (pick == 6) begin
      s.win_lo = SPAN_MIN;
      s.win_hi = SPAN_MAX;
    end else begin
      s.win_lo = year_instant($urandom_range(1601, 9000));
      s.win_hi = s.win_lo + longint'($urandom_range(1, 400)) * US_PER_YEAR;
      if (s.win_hi > WIN_MAX) s.win_hi = WIN_MAX;
    end
    pick = $urandom_range(0, 9);
    if (pick <= 5) s.drop_limit = DROP_MIN;
    else if (pick <= 7) s.drop_limit = year_instant($urandom_range(1601, 9999));
    else if (pick == 8) s.drop_limit = DROP_MAX;
    else s.drop_limit = {$urandom, $urandom};
    return s;
  endfunction

  function automatic logic [YEAR_W-1:0] random_year();
    if ($urandom_range(0, 4) == 0) return 14'($urandom);
    return 14'($urandom_range(1601, 9999));
  endfunction

  task automatic write_reg(ptzt_cfg_idx_t idx, logic [63:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
  endtask

  task automatic program_zone(tz_settings_t s);
    write_reg(CFG_START_RULE, 64'(s.start_rule));
    write_reg(CFG_END_RULE, 64'(s.end_rule));
    write_reg(CFG_STD_OFFSET, 64'(signed'(s.std_off)));
    write_reg(CFG_DST_OFFSET, 64'(signed'(s.dst_off)));
    write_reg(CFG_HAS_DST, 64'(s.has_dst));
    write_reg(CFG_WIN_START, s.win_lo);
    write_reg(CFG_WIN_END, s.win_hi);
    write_reg(CFG_LAST_EXPLICIT, s.drop_limit);
    cfg_wr_en = 1'b0;
    settings_used++;
  endtask

  task automatic send_year(logic [YEAR_W-1:0] yr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {2'b00, yr};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    years_sent++;
  endtask

  // years that keep no transition can still be in flight when the queue runs dry
  task automatic settle();
    in_tvalid = 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    send_idle_pct = 38;
    recv_idle_pct = 85;

    // defaults after reset: daylight saving off
    send_year(14'd2000);
    send_year(14'h3fff);
    settle();

    // default rules with daylight saving on
    write_reg(CFG_HAS_DST, 64'd1);
    cfg_wr_en = 1'b0;
    send_year(14'd1970);
    send_year(14'd1969);
    send_year(14'd9999);
    settle();

    // month-week-day rules, widest legal window
    zone.start_rule = pack_rule(KIND_M, 4'd3, 3'd2, 3'd0, 9'd0, 21'd7200);
    zone.end_rule = pack_rule(KIND_M, 4'd11, 3'd1, 3'd0, 9'd0, 21'd7200);
    zone.std_off = 18'(-18000);
    zone.dst_off = 18'(-14400);
    zone.has_dst = 1'b1;
    zone.win_lo = WIN_MIN;
    zone.win_hi = WIN_MAX;
    zone.drop_limit = DROP_MIN;
    program_zone(zone);
    send_year(14'd1601);
    send_year(14'd2024);
    send_year(14'd9999);
    send_year(14'd0);
    send_year(14'h3fff);
    settle();

    // out of range month, week and weekday fields; fifth week overrun
    zone.start_rule = pack_rule(KIND_M, 4'd0, 3'd0, 3'd7, 9'd0, 21'd3600);
    zone.end_rule = pack_rule(KIND_M, 4'd15, 3'd7, 3'd6, 9'd0, 21'd7200);
    program_zone(zone);
    send_year(14'd2023);
    send_year(14'd2024);
    settle();

    // julian days around feb 29, extreme rule times
    zone.start_rule = pack_rule(KIND_J, 4'd0, 3'd0, 3'd0, 9'd60, 21'h100000);
    zone.end_rule = pack_rule(KIND_J, 4'd0, 3'd0, 3'd0, 9'd0, 21'h0fffff);
    program_zone(zone);
    send_year(14'd2024);
    send_year(14'd2023);
    settle();

    // odd kind code, day past year end, full window span
    zone.start_rule = pack_rule(KIND_ODD, 4'hf, 3'h7, 3'h7, 9'd511, 21'd0);
    zone.end_rule = pack_rule(KIND_N, 4'd0, 3'd0, 3'd0, 9'd0, 21'd0);
    zone.win_lo = SPAN_MIN;
    zone.win_hi = SPAN_MAX;
    program_zone(zone);
    send_year(14'd0);
    send_year(14'd8191);
    settle();

    // start and end at the same instant
    zone.start_rule = pack_rule(KIND_N, 4'd0, 3'd0, 3'd0, 9'd100, 21'd0);
    zone.end_rule = zone.start_rule;
    zone.std_off = 18'd93600;
    zone.dst_off = 18'd93600;
    zone.win_lo = WIN_MIN;
    zone.win_hi = WIN_MAX;
    program_zone(zone);
    send_year(14'd2024);
    send_year(14'd1601);
    settle();

    // drop limit and window edges exactly on the instants
    zone.start_rule = pack_rule(KIND_N, 4'd0, 3'd0, 3'd0, 9'd10, 21'd0);
    zone.end_rule = pack_rule(KIND_N, 4'd0, 3'd0, 3'd0, 9'd20, 21'd0);
    zone.std_off = '0;
    zone.dst_off = '0;
    zone.drop_limit = JAN11_2000;
    zone.win_hi = JAN21_2000 + 1;
    program_zone(zone);
    send_year(14'd2000);
    settle();

    zone.drop_limit = DROP_MIN;
    zone.win_lo = JAN11_2000 + 1;
    zone.win_hi = JAN21_2000;
    program_zone(zone);
    send_year(14'd2000);
    settle();

    zone.drop_limit = JAN11_2000 - 1;
    zone.win_lo = JAN11_2000;
    zone.win_hi = JAN21_2000 + 1;
    program_zone(zone);
    send_year(14'd2000);
    send_year(14'd1999);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 38;
        recv_idle_pct = 85;
      end else if (p < 7) begin
        send_idle_pct = 85;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      zone = random_settings(p);
      program_zone(zone);
      repeat (YEARS_PER_PHASE) send_year(random_year());
      settle();
    end

    $display("sent %0d years under %0d zone settings: M, J and N rules, window and drop edges",
             years_sent, settings_used);
    $display("%0d transitions compared, %0d mismatches", transitions_seen, mismatches);
    if (mismatches == 0) begin
      $display("posix_tz_rule_transitions_test: done, clean");
    end else begin
      $display("posix_tz_rule_transitions_test: done, errors");
    end
    $finish;
  end

endmodule
